[rtl/uer_pkg.sv]
`default_nettype none

package uer_pkg;

    // default widths of the distance and echo count paths
    localparam int DIST_WIDTH_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    // fixed widths of counters, registers and the config port
    localparam int TICK_W     = 32;
    localparam int SCALE_W    = 32;
    localparam int PULSE_W    = 16;
    localparam int BOUND_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INCH_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BOUND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BOUND   = 3'd4;

    // register reset values
    localparam logic [PULSE_W-1:0] PULSE_TICKS_RST = 16'd750;
    localparam logic [TICK_W-1:0]  DELAY_TICKS_RST = 32'd4854250;
    localparam logic [SCALE_W-1:0] INCH_SCALE_RST  = 32'd581714;
    localparam logic [BOUND_W-1:0] MIN_BOUND_RST   = 16'd3;
    localparam logic [BOUND_W-1:0] MAX_BOUND_RST   = 16'd117;

    // per-tick flags handed from the sequencer to the result stage
    typedef struct packed {
        logic trigger;
        logic done;
        logic busy;
    } uer_flags_t;

endpackage

`default_nettype wire

[rtl/uer_ctrl.sv]
`default_nettype none

module uer_ctrl import uer_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire logic                           in_vld,
    input  wire logic                           echo,
    input  wire logic                           run,
    input  wire logic [PULSE_W-1:0]             pulse_ticks,
    input  wire logic [TICK_W-1:0]              delay_ticks,
    input  wire logic [SCALE_W-1:0]             inch_scale,
    output logic                                step_valid,
    output uer_flags_t                          flags,
    output logic [COUNT_WIDTH+SCALE_W-1:0]      product
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TRIG  = 3'd1;
    localparam logic [2:0] PH_RISE  = 3'd2;
    localparam logic [2:0] PH_HIGH  = 3'd3;
    localparam logic [2:0] PH_DELAY = 3'd4;

    localparam logic [TICK_W-1:0] COUNT_MAX = TICK_W'((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam logic [TICK_W-1:0] ONE_TICK  = TICK_W'(1);

    logic [2:0]                       phase_reg, phase_next;
    logic [TICK_W-1:0]                ctr_reg, ctr_next;
    logic                             step_valid_reg;
    uer_flags_t                       flags_reg, flags_next;
    logic [COUNT_WIDTH+SCALE_W-1:0]   product_reg, product_next;
    logic [TICK_W:0]                  ctr_inc;
    logic                             step;

    assign step    = in_vld && adv;
    assign ctr_inc = {1'b0, ctr_reg} + {{TICK_W{1'b0}}, 1'b1};

    // echo count times inches per tick, only used on the finishing tick
    assign product_next = ctr_reg[COUNT_WIDTH-1:0] * inch_scale;

    // phase sequencer, one step per accepted word
    always_comb
    begin
        phase_next = phase_reg;
        ctr_next   = ctr_reg;
        flags_next = '0;
        unique case (phase_reg)
            PH_TRIG:
            begin
                flags_next.trigger = 1'b1;
                ctr_next           = ctr_inc[TICK_W-1:0];
                if (ctr_inc >= {{(TICK_W+1-PULSE_W){1'b0}}, pulse_ticks})
                begin
                    phase_next = PH_RISE;
                end
            end
            PH_RISE:
            begin
                if (echo)
                begin
                    ctr_next   = ONE_TICK;
                    phase_next = PH_HIGH;
                end
            end
            PH_HIGH:
            begin
                if (echo)
                begin
                    if (ctr_reg < COUNT_MAX)
                    begin
                        ctr_next = ctr_inc[TICK_W-1:0];
                    end
                end
                else
                begin
                    flags_next.done = 1'b1;
                    ctr_next        = '0;
                    phase_next      = (delay_ticks == '0) ? PH_IDLE : PH_DELAY;
                end
            end
            PH_DELAY:
            begin
                if (ctr_inc >= {1'b0, delay_ticks})
                begin
                    ctr_next   = '0;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    ctr_next = ctr_inc[TICK_W-1:0];
                end
            end
            default:
            begin
                // idle, and any unused code behaves as idle
                phase_next = PH_IDLE;
                if (run)
                begin
                    flags_next.trigger = 1'b1;
                    ctr_next           = ONE_TICK;
                    phase_next = (pulse_ticks <= PULSE_W'(1)) ? PH_RISE : PH_TRIG;
                end
            end
        endcase
        flags_next.busy = (phase_next != PH_IDLE);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            ctr_reg        <= '0;
            step_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            step_valid_reg <= in_vld;
            if (in_vld)
            begin
                phase_reg <= phase_next;
                ctr_reg   <= ctr_next;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            flags_reg   <= flags_next;
            product_reg <= product_next;
        end
    end

    assign step_valid = step_valid_reg;
    assign flags      = flags_reg;
    assign product    = product_reg;

endmodule

`default_nettype wire

[rtl/uer_stats.sv]
`default_nettype none

module uer_stats import uer_pkg::*; #(
    parameter int DIST_WIDTH  = DIST_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire logic                           step_valid,
    input  wire uer_flags_t                     flags,
    input  wire logic [COUNT_WIDTH+SCALE_W-1:0] product,
    input  wire logic [BOUND_W-1:0]             min_bound,
    input  wire logic [BOUND_W-1:0]             max_bound,
    output logic                                out_valid,
    output logic                                trigger,
    output logic                                done_res,
    output logic [DIST_WIDTH-1:0]               distance,
    output logic                                in_range,
    output logic [DIST_WIDTH-1:0]               max_distance,
    output logic [DIST_WIDTH-1:0]               min_distance,
    output logic                                busy_res
);

    localparam int CMP_W = (DIST_WIDTH > COUNT_WIDTH) ? DIST_WIDTH : COUNT_WIDTH;
    localparam logic [CMP_W-1:0] DMAX_X = CMP_W'((64'd1 << DIST_WIDTH) - 64'd1);

    logic                     out_valid_reg;
    uer_flags_t               flags_reg;
    logic [DIST_WIDTH-1:0]    dist_reg, dist_next;
    logic                     in_range_reg, in_range_next;
    logic [DIST_WIDTH-1:0]    largest_reg, largest_next;
    logic [DIST_WIDTH-1:0]    smallest_reg, smallest_next;
    logic [CMP_W-1:0]         quot_x;
    logic [CMP_W-1:0]         dist_x;
    logic                     take;

    assign take = step_valid && adv;

    // integer inches, saturated to the distance width
    assign quot_x = CMP_W'(product[COUNT_WIDTH+SCALE_W-1:SCALE_W]);
    assign dist_x = (quot_x > DMAX_X) ? DMAX_X : quot_x;

    // range check and running extremes on a finished measurement
    always_comb
    begin
        dist_next     = dist_reg;
        in_range_next = in_range_reg;
        largest_next  = largest_reg;
        smallest_next = smallest_reg;
        if (flags.done)
        begin
            dist_next     = dist_x[DIST_WIDTH-1:0];
            in_range_next = (dist_x > CMP_W'(min_bound)) && (dist_x < CMP_W'(max_bound));
            if (in_range_next)
            begin
                if (dist_next > largest_reg)
                begin
                    largest_next = dist_next;
                end
                if (dist_next < smallest_reg)
                begin
                    smallest_next = dist_next;
                end
            end
        end
    end

    // measurement state, shown directly on the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            dist_reg      <= '0;
            in_range_reg  <= 1'b0;
            largest_reg   <= '0;
            smallest_reg  <= '1;
        end
        else if (adv)
        begin
            out_valid_reg <= step_valid;
            if (step_valid)
            begin
                dist_reg     <= dist_next;
                in_range_reg <= in_range_next;
                largest_reg  <= largest_next;
                smallest_reg <= smallest_next;
            end
        end
    end

    // per-tick flags of the output word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            flags_reg <= flags;
        end
    end

    assign out_valid    = out_valid_reg;
    assign trigger      = flags_reg.trigger;
    assign done_res     = flags_reg.done;
    assign busy_res     = flags_reg.busy;
    assign distance     = dist_reg;
    assign in_range     = in_range_reg;
    assign max_distance = largest_reg;
    assign min_distance = smallest_reg;

endmodule

`default_nettype wire

[rtl/ultrasonic_echo_ranger_top.sv]
`default_nettype none

// channel   valid      ready      payload
// in        in_valid   in_ready   echo, run
// out       out_valid  out_ready  trigger, done_res, distance, in_range,
//                                 max_distance, min_distance, busy_res
// cfg       cfg_valid  cfg_ready  cfg_index, cfg_data
//
// one word in and one word out per cycle unless a waiting word stalls out; a word taken passes the
// sequencer and product register, then the result register, before it shows on out
// the count times scale multiply is registered before saturation and range check
// reset returns the sequencer to idle and the extremes to none seen; no clearing pass
// a word waiting on out with out_ready low freezes all three stages and drops in_ready
// cfg_ready is always high

module ultrasonic_echo_ranger_top import uer_pkg::*; #(
    parameter int DIST_WIDTH  = DIST_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    echo,
    input  wire logic                    run,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         trigger,
    output logic                         done_res,
    output logic [DIST_WIDTH-1:0]        distance,
    output logic                         in_range,
    output logic [DIST_WIDTH-1:0]        max_distance,
    output logic [DIST_WIDTH-1:0]        min_distance,
    output logic                         busy_res,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    logic [PULSE_W-1:0]               pulse_ticks_reg;
    logic [TICK_W-1:0]                delay_ticks_reg;
    logic [SCALE_W-1:0]               inch_scale_reg;
    logic [BOUND_W-1:0]               min_bound_reg;
    logic [BOUND_W-1:0]               max_bound_reg;
    logic                             in_vld_reg;
    logic                             echo_reg;
    logic                             run_reg;
    logic                             adv;
    logic                             step_valid;
    uer_flags_t                       flags;
    logic [COUNT_WIDTH+SCALE_W-1:0]   product;

    // whole pipeline moves when the output word is empty or being taken
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_ticks_reg <= PULSE_TICKS_RST;
            delay_ticks_reg <= DELAY_TICKS_RST;
            inch_scale_reg  <= INCH_SCALE_RST;
            min_bound_reg   <= MIN_BOUND_RST;
            max_bound_reg   <= MAX_BOUND_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PULSE_TICKS: pulse_ticks_reg <= cfg_data[PULSE_W-1:0];
                REG_DELAY_TICKS: delay_ticks_reg <= cfg_data[TICK_W-1:0];
                REG_INCH_SCALE:  inch_scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_MIN_BOUND:   min_bound_reg   <= cfg_data[BOUND_W-1:0];
                REG_MAX_BOUND:   max_bound_reg   <= cfg_data[BOUND_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && adv)
        begin
            echo_reg <= echo;
            run_reg  <= run;
        end
    end

    uer_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_vld      (in_vld_reg),
        .echo        (echo_reg),
        .run         (run_reg),
        .pulse_ticks (pulse_ticks_reg),
        .delay_ticks (delay_ticks_reg),
        .inch_scale  (inch_scale_reg),
        .step_valid  (step_valid),
        .flags       (flags),
        .product     (product)
    );

    uer_stats #(
        .DIST_WIDTH  (DIST_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_stats (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .step_valid   (step_valid),
        .flags        (flags),
        .product      (product),
        .min_bound    (min_bound_reg),
        .max_bound    (max_bound_reg),
        .out_valid    (out_valid),
        .trigger      (trigger),
        .done_res     (done_res),
        .distance     (distance),
        .in_range     (in_range),
        .max_distance (max_distance),
        .min_distance (min_distance),
        .busy_res     (busy_res)
    );

    // a driven trigger always leaves the sequencer busy
    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trigger |-> busy_res)
        else $error("trigger without busy");

    // a measurement never finishes while the trigger is driven
    a_done_no_trig: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !trigger)
        else $error("done during trigger");

    // once any in-range reading exists the extremes are ordered
    a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        max_distance != '0 |-> min_distance <= max_distance)
        else $error("extremes out of order");

    // an in-range finished reading lies within the extremes
    a_in_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res && in_range |->
            min_distance <= distance && distance <= max_distance)
        else $error("reading outside extremes");

endmodule

`default_nettype wire
